>>> sv/gjps_pkg.sv
// shared types and constants for the jump point scan block
`timescale 1ns / 1ps
`default_nettype none
package gjps_pkg;
  localparam int unsigned CoordBits = 8;
  localparam int unsigned DirBits = 3;
  localparam int unsigned StartCostBits = 24;
  localparam int unsigned CfgBits = 9;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] RegMapWidth = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegMapHeight = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegGoalX = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegGoalY = 2'd3;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdScan = 1'b1;

  localparam int unsigned StraightCost = 10;
  localparam int unsigned DiagCost = 14;

  // signed unit step of a direction, x and y
  function automatic logic signed [1:0] step_dx(input logic [DirBits-1:0] d);
    case (d)
      3'd0, 3'd1, 3'd7: step_dx = 2'sd1;
      3'd3, 3'd4, 3'd5: step_dx = -2'sd1;
      default: step_dx = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] step_dy(input logic [DirBits-1:0] d);
    case (d)
      3'd1, 3'd2, 3'd3: step_dy = 2'sd1;
      3'd5, 3'd6, 3'd7: step_dy = -2'sd1;
      default: step_dy = 2'sd0;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> sv/grid_jump_point_scan.sv
// top level of the jump point scan block
// usage:
//  - input channel (valid/stall): a word is a command; command 0 writes one
//    obstacle map cell, command 1 runs a jump scan from cell_x/cell_y in
//    direction with start_cost
//  - output channel (valid/stall): one word per input word; writes return
//    all zero fields, scans return found plus the jump point and its cost
//  - config port: cfg_we/cfg_index/cfg_data set map size and goal cell;
//    the user must write it only while idle; the block does not enforce it
//  - sequencing: one word at a time; a write goes straight to the output
//    register; a scan walks cells through the single map read port, each
//    cell taking five probes (an address and a wait phase each) and an
//    evaluation; a hit or a blocked cell goes through cost and done states;
//    diagonal scans add both straight sub-scans at every diagonal cell
//  - cost saturates at all ones of COST_BITS
//  - reset: clears control and the config registers to full map and goal
//    at the origin; the map itself holds nothing until written
//  - a stalled result holds in the output register; no new word is taken
//    until it has been delivered
`timescale 1ns / 1ps
`default_nettype none
module grid_jump_point_scan
  import gjps_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned COST_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIdxBits-1:0]    cfg_index,
  input  wire logic [CfgBits-1:0]       cfg_data,
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic                     command,
  input  wire logic [CoordBits-1:0]     cell_x,
  input  wire logic [CoordBits-1:0]     cell_y,
  input  wire logic                     blocked,
  input  wire logic [DirBits-1:0]       direction,
  input  wire logic [StartCostBits-1:0] start_cost,
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic                     found,
  output      logic [CoordBits-1:0]     jump_x,
  output      logic [CoordBits-1:0]     jump_y,
  output      logic [COST_BITS-1:0]     jump_cost
);
  localparam int unsigned XB = $clog2(MAX_WIDTH);
  localparam int unsigned YB = $clog2(MAX_HEIGHT);

  // config registers
  logic [CfgBits-1:0] map_width, map_height;
  logic [CoordBits-1:0] goal_x, goal_y;
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= CfgBits'(256);
      map_height <= CfgBits'(256);
      goal_x <= '0;
      goal_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMapWidth: map_width <= cfg_data;
        RegMapHeight: map_height <= cfg_data;
        RegGoalX: goal_x <= cfg_data[CoordBits-1:0];
        RegGoalY: goal_y <= cfg_data[CoordBits-1:0];
        default: ;
      endcase
    end
  end

  // effective map size, capped at the store
  logic [XB:0] w_lim;
  logic [YB:0] h_lim;
  always_comb begin
    if (32'(map_width) > MAX_WIDTH) w_lim = (XB + 1)'(MAX_WIDTH);
    else w_lim = (XB + 1)'(map_width);
    if (32'(map_height) > MAX_HEIGHT) h_lim = (YB + 1)'(MAX_HEIGHT);
    else h_lim = (YB + 1)'(map_height);
  end

  logic busy;
  logic accept;
  assign in_stall = busy;
  assign accept = in_valid && !busy;

  // map write path
  logic wr_ok;
  assign wr_ok = accept && command == CmdWrite &&
                 32'(cell_x) < MAX_WIDTH && 32'(cell_y) < MAX_HEIGHT;

  logic seq_rd_en;
  logic [XB-1:0] rd_x;
  logic [YB-1:0] rd_y;
  logic rd_bit;
  logic [XB+YB-1:0] addr;
  always_comb begin
    if (accept && command == CmdWrite)
      addr = {YB'(cell_y), XB'(cell_x)};
    else
      addr = {rd_y, rd_x};
  end

  // store rows are padded to a power of two so the address is {row, column}
  gjps_ram #(.WIDTH(1), .DEPTH((1 << XB) * (1 << YB))) u_map (
    .clk(clk), .we(wr_ok), .addr(addr), .wdata(blocked), .rdata(rd_bit)
  );

  logic s_done, s_hit;
  logic [CoordBits-1:0] s_hx, s_hy;
  logic [COST_BITS-1:0] s_cost;
  gjps_seq #(.XB(XB), .YB(YB), .COST_BITS(COST_BITS)) u_seq (
    .clk(clk), .rst(rst),
    .start(accept && command == CmdScan),
    .sx(cell_x), .sy(cell_y), .dir(direction), .scost(start_cost),
    .w_lim(w_lim), .h_lim(h_lim), .gx(goal_x), .gy(goal_y),
    .rd_en(seq_rd_en), .rd_x(rd_x), .rd_y(rd_y), .rd_bit(rd_bit),
    .done(s_done), .hit(s_hit), .hx(s_hx), .hy(s_hy), .hcost(s_cost)
  );

  // output register; busy until the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
        busy <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        if (command == CmdWrite) begin
          out_valid <= 1'b1;
          found <= 1'b0; jump_x <= '0; jump_y <= '0; jump_cost <= '0;
        end
      end else if (s_done && seq_rd_en) begin
        out_valid <= 1'b1;
        found <= s_hit;
        jump_x <= s_hit ? s_hx : '0;
        jump_y <= s_hit ? s_hy : '0;
        jump_cost <= s_hit ? s_cost : '0;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/gjps_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module gjps_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> sv/gjps_seq.sv
// scan sequencer: walks cells one map read at a time
`timescale 1ns / 1ps
`default_nettype none
module gjps_seq
  import gjps_pkg::*;
#(
  parameter int unsigned XB = 8,
  parameter int unsigned YB = 8,
  parameter int unsigned COST_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [CoordBits-1:0]     sx,
  input  wire logic [CoordBits-1:0]     sy,
  input  wire logic [DirBits-1:0]       dir,
  input  wire logic [StartCostBits-1:0] scost,
  input  wire logic [XB:0]              w_lim,
  input  wire logic [YB:0]              h_lim,
  input  wire logic [CoordBits-1:0]     gx,
  input  wire logic [CoordBits-1:0]     gy,
  output      logic                     rd_en,
  output      logic [XB-1:0]            rd_x,
  output      logic [YB-1:0]            rd_y,
  input  wire logic                     rd_bit,
  output      logic                     done,
  output      logic                     hit,
  output      logic [CoordBits-1:0]     hx,
  output      logic [CoordBits-1:0]     hy,
  output      logic [COST_BITS-1:0]     hcost
);
  localparam int unsigned MB = XB > YB ? XB : YB;
  localparam int unsigned CB = (MB > CoordBits ? MB : CoordBits) + 2;
  // accumulator holds the full start cost plus every step
  localparam int unsigned AB = (COST_BITS > StartCostBits ? COST_BITS : StartCostBits) + 1;
  typedef logic signed [CB-1:0] crd_t;

  // phases: check next cell blocked, read side a, beyond a, side b, beyond b
  typedef enum logic [3:0] {
    S_IDLE, S_CELL, S_CELL_W, S_SA, S_SA_W, S_NA, S_NA_W,
    S_SB, S_SB_W, S_NB, S_NB_W, S_EVAL, S_COST, S_DONE
  } state_t;

  state_t state;
  logic [DirBits-1:0] mdir, cdir;     // main and current scan direction
  logic sub;                          // in a straight sub-scan
  logic second;                       // second sub-scan
  crd_t mx, my, cx, cy, px, py;
  logic sa, na, sb, nb;
  logic [AB-1:0] cost;
  logic [4:0] unit;
  logic rd_in;

  logic [DirBits-1:0] off;
  logic [DirBits-1:0] d_sa, d_na, d_sb, d_nb;
  assign off = {2'b00, cdir[0]};
  assign d_sa = cdir + 3'd2 + off;
  assign d_na = cdir + 3'd1 + off;
  assign d_sb = cdir + 3'd6 - off;
  assign d_nb = cdir + 3'd7 - off;

  // probe address for the current phase
  logic [DirBits-1:0] pd;
  always_comb begin
    case (state)
      S_SA: pd = d_sa;
      S_NA: pd = d_na;
      S_SB: pd = d_sb;
      S_NB: pd = d_nb;
      default: pd = cdir;
    endcase
  end
  crd_t qx, qy;
  always_comb begin
    if (state == S_CELL) begin
      qx = cx + crd_t'(step_dx(cdir));
      qy = cy + crd_t'(step_dy(cdir));
    end else begin
      qx = cx + crd_t'(step_dx(pd));
      qy = cy + crd_t'(step_dy(pd));
    end
  end
  logic q_out;
  assign q_out = qx < 0 || qy < 0 || qx >= crd_t'(w_lim) || qy >= crd_t'(h_lim);
  assign rd_en = 1'b1;
  assign rd_x = qx[XB-1:0];
  assign rd_y = qy[YB-1:0];

  logic blk;
  assign blk = !rd_in || rd_bit;
  logic is_goal;
  assign is_goal = cx >= 0 && cy >= 0 && cx == crd_t'({1'b0, gx}) && cy == crd_t'({1'b0, gy});
  logic jmp;
  assign jmp = is_goal || (sa && !na) || (sb && !nb);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          mdir <= dir; cdir <= dir; sub <= 1'b0; second <= 1'b0;
          cx <= crd_t'({1'b0, sx}); cy <= crd_t'({1'b0, sy});
          mx <= crd_t'({1'b0, sx}); my <= crd_t'({1'b0, sy});
          cost <= AB'(scost);
          unit <= dir[0] ? 5'(DiagCost) : 5'(StraightCost);
          hit <= 1'b0;
          state <= S_CELL;
        end
        S_CELL: begin
          rd_in <= !q_out; px <= qx; py <= qy; state <= S_CELL_W;
        end
        S_CELL_W: begin
          if (blk) begin
            if (!sub) state <= S_COST;
            else if (!second) begin
              second <= 1'b1; cdir <= mdir + 3'd7; cx <= mx; cy <= my; state <= S_CELL;
            end else begin
              sub <= 1'b0; cdir <= mdir; cx <= mx; cy <= my; state <= S_CELL;
            end
          end else begin
            cx <= px; cy <= py;
            if (!sub) begin
              mx <= px; my <= py;
              cost <= cost + AB'(unit);
            end
            state <= S_SA;
          end
        end
        S_SA: begin rd_in <= !q_out; state <= S_SA_W; end
        S_SA_W: begin sa <= blk; state <= S_NA; end
        S_NA: begin rd_in <= !q_out; state <= S_NA_W; end
        S_NA_W: begin na <= blk; state <= S_SB; end
        S_SB: begin rd_in <= !q_out; state <= S_SB_W; end
        S_SB_W: begin sb <= blk; state <= S_NB; end
        S_NB: begin rd_in <= !q_out; state <= S_NB_W; end
        S_NB_W: begin nb <= blk; state <= S_EVAL; end
        S_EVAL: begin
          if (jmp) begin
            hit <= 1'b1; state <= S_COST;
          end else if (!sub && mdir[0]) begin
            sub <= 1'b1; second <= 1'b0; cdir <= mdir + 3'd1; state <= S_CELL;
          end else state <= S_CELL;
        end
        S_COST: begin
          hx <= mx[CoordBits-1:0];
          hy <= my[CoordBits-1:0];
          if (cost > AB'({COST_BITS{1'b1}}))
            hcost <= '1;
          else hcost <= cost[COST_BITS-1:0];
          state <= S_DONE;
        end
        S_DONE: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> verif/gjps_checker.sv
// checker for the jump point scan block: predicts every result word and compares
`timescale 1ns / 1ps
module gjps_checker
  import gjps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIdxBits-1:0]    cfg_index,
  input  logic [CfgBits-1:0]       cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     command,
  input  logic [CoordBits-1:0]     cell_x,
  input  logic [CoordBits-1:0]     cell_y,
  input  logic                     blocked,
  input  logic [DirBits-1:0]       direction,
  input  logic [StartCostBits-1:0] start_cost,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     found,
  input  logic [CoordBits-1:0]     jump_x,
  input  logic [CoordBits-1:0]     jump_y,
  input  logic [23:0]              jump_cost,
  output int                       fail_count,
  output int                       words_pending
);
  localparam int GridW = 256;
  localparam int GridH = 256;
  localparam longint CostMax = (64'd1 << 24) - 1;

  typedef struct packed {
    logic       found;
    logic [7:0] x;
    logic [7:0] y;
    logic [23:0] cost;
  } jump_word_t;

  bit         obstacles[GridW*GridH];
  int         width_reg, height_reg, goal_col, goal_row;
  jump_word_t jump_q[$];

  function automatic int dx_of(int d);
    case (d & 7)
      0, 1, 7: return 1;
      3, 4, 5: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int dy_of(int d);
    case (d & 7)
      1, 2, 3: return 1;
      5, 6, 7: return -1;
      default: return 0;
    endcase
  endfunction

  // outside the map counts as an obstacle
  function automatic bit wall_at(int x, int y);
    int w, h;
    w = (width_reg > GridW) ? GridW : width_reg;
    h = (height_reg > GridH) ? GridH : height_reg;
    if (x < 0 || y < 0 || x >= w || y >= h) return 1;
    return obstacles[y*GridW + x];
  endfunction

  function automatic bit forced_at(int x, int y, int chk, int nb);
    return wall_at(x + dx_of(chk), y + dy_of(chk)) && !wall_at(x + dx_of(nb), y + dy_of(nb));
  endfunction

  function automatic bit jump_cell(int x, int y, int d);
    int off;
    off = d & 1;
    if (x == goal_col && y == goal_row) return 1;
    if (forced_at(x, y, d + 2 + off, d + 1 + off)) return 1;
    return forced_at(x, y, d + 6 - off, d + 7 - off);
  endfunction

  function automatic bit line_reaches(int x, int y, int d);
    int cx, cy;
    cx = x + dx_of(d);
    cy = y + dy_of(d);
    while (!wall_at(cx, cy)) begin
      if (jump_cell(cx, cy, d & 7)) return 1;
      cx += dx_of(d);
      cy += dy_of(d);
    end
    return 0;
  endfunction

  function automatic jump_word_t scan_result(int sx, int sy, int d, longint base);
    jump_word_t r;
    int cx, cy;
    longint steps, unit, total;
    bit hit;
    r = '0;
    unit = (d & 1) ? DiagCost : StraightCost;
    steps = 1;
    cx = sx + dx_of(d);
    cy = sy + dy_of(d);
    while (!wall_at(cx, cy)) begin
      hit = jump_cell(cx, cy, d);
      if (!hit && (d & 1)) hit = line_reaches(cx, cy, d + 1) || line_reaches(cx, cy, d + 7);
      if (hit) begin
        total = base + unit * steps;
        if (total > CostMax) total = CostMax;
        r.found = 1;
        r.x = cx[7:0];
        r.y = cy[7:0];
        r.cost = total[23:0];
        return r;
      end
      cx += dx_of(d);
      cy += dy_of(d);
      steps++;
    end
    return r;
  endfunction

  assign words_pending = jump_q.size();

  always @(posedge clk) begin
    jump_word_t exp_w;
    if (rst) begin
      width_reg <= GridW;
      height_reg <= GridH;
      goal_col <= 0;
      goal_row <= 0;
      jump_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegMapWidth:  width_reg <= cfg_data;
          RegMapHeight: height_reg <= cfg_data;
          RegGoalX:     goal_col <= cfg_data[7:0];
          RegGoalY:     goal_row <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (command == CmdWrite) begin
          obstacles[cell_y*GridW + cell_x] = blocked;
          jump_q.push_back('0);
        end else begin
          jump_q.push_back(scan_result(cell_x, cell_y, direction, start_cost));
        end
      end
      if (out_valid && !out_stall) begin
        if (jump_q.size() == 0) begin
          $display("%0t: unexpected word found=%0d x=%0d y=%0d cost=%0d", $time,
                   found, jump_x, jump_y, jump_cost);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = jump_q.pop_front();
          if (exp_w != {found, jump_x, jump_y, jump_cost}) begin
            $display("%0t: mismatch expected found=%0d x=%0d y=%0d cost=%0d", $time,
                     exp_w.found, exp_w.x, exp_w.y, exp_w.cost);
            $display("%0t:          actual   found=%0d x=%0d y=%0d cost=%0d", $time,
                     found, jump_x, jump_y, jump_cost);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> verif/tb.sv
// testbench top: stimulus, idling, config phases and the verdict
`timescale 1ns / 1ps
module tb;
  import gjps_pkg::*;

  localparam longint CycleLimit = 40_000_000;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CfgIdxBits-1:0]    cfg_index;
  logic [CfgBits-1:0]       cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     command;
  logic [CoordBits-1:0]     cell_x;
  logic [CoordBits-1:0]     cell_y;
  logic                     blocked;
  logic [DirBits-1:0]       direction;
  logic [StartCostBits-1:0] start_cost;
  logic                     out_valid;
  logic                     out_stall;
  logic                     found;
  logic [CoordBits-1:0]     jump_x;
  logic [CoordBits-1:0]     jump_y;
  logic [23:0]              jump_cost;
  int                       fail_count;
  int                       words_pending;

  // idling knobs, percent per cycle
  int     send_idle_pct;
  int     recv_stall_pct;
  // long receiver hold-off request, serviced by its own process
  bit     hold_req;
  int     hold_left;
  longint cycle_count;

  // which cells the map store holds a defined value for
  bit     cell_known[65536];
  int     map_cols, map_rows, goal_col, goal_row;

  grid_jump_point_scan uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .cell_x(cell_x), .cell_y(cell_y), .blocked(blocked),
    .direction(direction), .start_cost(start_cost),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .jump_x(jump_x), .jump_y(jump_y), .jump_cost(jump_cost)
  );

  gjps_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .cell_x(cell_x), .cell_y(cell_y), .blocked(blocked),
    .direction(direction), .start_cost(start_cost),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .jump_x(jump_x), .jump_y(jump_y), .jump_cost(jump_cost),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver side: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1;
      hold_left <= 3000;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one word and hold it until accepted
  task automatic send_word(input logic cmd, input int x, input int y, input logic obst,
                           input int d, input logic [23:0] cost);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    cell_x <= x[7:0];
    cell_y <= y[7:0];
    blocked <= obst;
    direction <= d[2:0];
    start_cost <= cost;
    do @(posedge clk); while (in_stall);
    if (cmd == CmdWrite && x < 256 && y < 256) cell_known[y*256 + x] = 1;
  endtask

  // config only once the block has drained
  task automatic set_phase(input int w, input int h, input int gx, input int gy);
    in_valid <= 0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= RegMapWidth;  cfg_data <= w[8:0];  @(posedge clk);
    cfg_index <= RegMapHeight; cfg_data <= h[8:0];  @(posedge clk);
    cfg_index <= RegGoalX;     cfg_data <= gx[8:0]; @(posedge clk);
    cfg_index <= RegGoalY;     cfg_data <= gy[8:0]; @(posedge clk);
    cfg_we <= 0;
    map_cols = (w > 256) ? 256 : w;
    map_rows = (h > 256) ? 256 : h;
    goal_col = gx;
    goal_row = gy;
  endtask

  // every cell the scans can read must be defined first
  task automatic fill_map(input int density);
    for (int y = 0; y < map_rows; y++)
      for (int x = 0; x < map_cols; x++)
        if (!cell_known[y*256 + x])
          send_word(CmdWrite, x, y, ($urandom_range(99) < density), $urandom_range(7),
                    24'($urandom));
  endtask

  task automatic random_words(input int count, input int density);
    int x, y;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 35) begin
        // writes mostly land in the map, sometimes anywhere in the store
        if ($urandom_range(9) == 0) begin
          x = $urandom_range(255);
          y = $urandom_range(255);
        end else begin
          x = $urandom_range(map_cols - 1);
          y = $urandom_range(map_rows - 1);
        end
        send_word(CmdWrite, x, y, ($urandom_range(99) < density), $urandom_range(7),
                  24'($urandom));
      end else begin
        if ($urandom_range(9) == 0) begin
          x = $urandom_range(255);
          y = $urandom_range(255);
        end else begin
          x = $urandom_range(map_cols);
          y = $urandom_range(map_rows);
        end
        send_word(CmdScan, x, y, $urandom_range(1), $urandom_range(7),
                  ($urandom_range(9) == 0) ? 24'(24'hFFFFF0 + $urandom_range(15))
                                           : 24'($urandom));
      end
    end
  endtask

  task automatic pick_idle(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  initial begin
    int w, h;
    rst = 1;
    cfg_we = 0;
    cfg_index = RegMapWidth;
    cfg_data = 0;
    in_valid = 0;
    command = CmdWrite;
    cell_x = 0;
    cell_y = 0;
    blocked = 0;
    direction = 0;
    start_cost = 0;
    hold_req = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    map_cols = 256;
    map_rows = 256;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: small 8x8 map, goal inside
    set_phase(8, 8, 5, 3);
    fill_map(25);
    send_word(CmdWrite, 2, 2, 1, 0, 0);
    send_word(CmdWrite, 255, 255, 1, 0, 0);   // beyond the map, inside the store
    for (int d = 0; d < 8; d++)
      send_word(CmdScan, 3, 3, 0, d, 24'(100 * d));
    send_word(CmdScan, 0, 3, 0, 0, 24'hFFFFFF);   // saturated cost
    send_word(CmdScan, 0, 3, 0, 0, 24'hFFFFF8);   // saturates on the step
    send_word(CmdScan, 2, 2, 1, 1, 0);            // start cell is blocked
    send_word(CmdScan, 255, 255, 0, 5, 7);        // start far outside the map
    send_word(CmdScan, 8, 3, 0, 4, 0);            // start just past the edge
    send_word(CmdScan, 7, 7, 0, 1, 0);            // steps straight off the map
    send_word(CmdScan, 0, 0, 0, 3, 0);

    // width above the store acts as full width, single row
    set_phase(511, 1, 200, 0);
    fill_map(10);
    for (int d = 0; d < 8; d += 4) begin
      send_word(CmdScan, 0, 0, 0, d, 0);
      send_word(CmdScan, 255, 0, 0, d, 24'h123456);
    end
    // full height, single column, goal outside the map
    set_phase(1, 256, 255, 100);
    fill_map(10);
    send_word(CmdScan, 0, 0, 0, 2, 0);
    send_word(CmdScan, 0, 255, 0, 6, 0);
    // zero size: every cell blocked
    set_phase(0, 5, 0, 0);
    for (int d = 0; d < 8; d++) send_word(CmdScan, 1, 1, 0, d, 5);

    // random phases over small maps
    for (int p = 0; p < 12; p++) begin
      w = (p % 3 == 0) ? 16 : $urandom_range(16, 2);
      h = (p % 4 == 1) ? 1 : $urandom_range(16, 2);
      if ($urandom_range(3) == 0) set_phase(w, h, $urandom_range(255), $urandom_range(255));
      else set_phase(w, h, $urandom_range(w - 1), $urandom_range(h - 1));
      pick_idle(p);
      fill_map(20 + 3 * p);
      if (p == 5) begin
        // long receiver hold-off while the sender keeps offering
        hold_req <= 1;
        @(posedge clk);
        hold_req <= 0;
      end
      random_words(70, 15 + 3 * p);
      if (p % 4 == 3) begin
        // stretch with no idling inside the phase
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_words(15, 25);
      end
    end

    in_valid <= 0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> sim.f
sv/gjps_pkg.sv
sv/gjps_ram.sv
sv/gjps_seq.sv
sv/grid_jump_point_scan.sv
verif/gjps_checker.sv
verif/tb.sv
